FILE: hdl/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// Used by the sequencer and the top level; depends on nothing.
`timescale 1ns / 1ps

package mhpq_pkg;

   localparam int KEY_W            = 32;
   localparam int COUNT_W          = 7;
   localparam int DEFAULT_CAPACITY = 64;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]   max_key;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

FILE: hdl/mhpq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
`timescale 1ns / 1ps

module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/mhpq_ctrl.sv
// Heap sequencer: sift-up and sift-down over the heap RAM with one shared comparator.
// Depends on mhpq_pkg; drives the ports of one mhpq_ram instance.
`timescale 1ns / 1ps

module mhpq_ctrl #(
   parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [mhpq_pkg::KEY_W-1:0]    req_key,
   output logic                          ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0]   ram_wr_addr,
   output logic [mhpq_pkg::KEY_W-1:0]    ram_wr_data,
   output logic                          ram_rd_en,
   output logic [$clog2(CAPACITY)-1:0]   ram_rd_addr,
   input  logic [mhpq_pkg::KEY_W-1:0]    ram_rd_data,
   output logic                          res_valid,
   input  logic                          res_ready,
   output mhpq_pkg::result_type          res
);

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_UP_RD  = 10'b0000000010,
      ST_UP_CMP = 10'b0000000100,
      ST_RM_RD1 = 10'b0000001000,
      ST_RM_RD2 = 10'b0000010000,
      ST_DN_CHK = 10'b0000100000,
      ST_DN_LD  = 10'b0001000000,
      ST_DN_SEL = 10'b0010000000,
      ST_DN_CMP = 10'b0100000000,
      ST_RESP   = 10'b1000000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [PW-1:0]                 cnt_ff, cnt_in;
   logic [PW-1:0]                 pos_ff, pos_in;
   logic [PW-1:0]                 child_ff, child_in;
   logic [mhpq_pkg::KEY_W-1:0]    val_ff, val_in;
   logic [mhpq_pkg::KEY_W-1:0]    ckey_ff, ckey_in;
   logic [mhpq_pkg::KEY_W-1:0]    mk_ff, mk_in;
   mhpq_pkg::status_type          status_ff, status_in;

   logic signed [mhpq_pkg::KEY_W-1:0] cmp_a, cmp_b;
   logic                              cmp_gt;

   logic [PW-1:0]                 pos_m1, cnt_m1, parent, parent_m1;
   logic [PW:0]                   left, left_m1, right;
   logic                          left_out, right_in;
   logic [PW+mhpq_pkg::COUNT_W-1:0] cnt_wide;

   assign pos_m1    = pos_ff - PW'(1);
   assign cnt_m1    = cnt_ff - PW'(1);
   assign parent    = pos_ff >> 1;
   assign parent_m1 = parent - PW'(1);
   assign left      = {pos_ff, 1'b0};
   assign left_m1   = left - (PW + 1)'(1);
   assign right     = left + (PW + 1)'(1);
   assign left_out  = left > {1'b0, cnt_ff};
   assign right_in  = right <= {1'b0, cnt_ff};

   // The single comparator of the datapath.
   assign cmp_gt = cmp_a > cmp_b;

   always_comb begin
      cmp_a = val_ff;
      cmp_b = ram_rd_data;
      unique case (state_ff)
         ST_DN_SEL: begin
            cmp_a = ckey_ff;
            cmp_b = ram_rd_data;
         end
         ST_DN_CMP: begin
            cmp_a = ckey_ff;
            cmp_b = val_ff;
         end
         default: begin
            cmp_a = val_ff;
            cmp_b = ram_rd_data;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      child_in    = child_ff;
      val_in      = val_ff;
      ckey_in     = ckey_ff;
      mk_in       = mk_ff;
      status_in   = status_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_m1[AW-1:0];
      ram_wr_data = val_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mk_in     = '0;
               status_in = mhpq_pkg::STATUS_OK;
               if (req_cmd == mhpq_pkg::CMD_INSERT) begin
                  if (cnt_ff == PW'(CAPACITY)) begin
                     status_in = mhpq_pkg::STATUS_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     cnt_in   = cnt_ff + PW'(1);
                     pos_in   = cnt_ff + PW'(1);
                     val_in   = req_key;
                     state_in = ST_UP_RD;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = mhpq_pkg::STATUS_EMPTY;
                     state_in  = ST_RESP;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = ST_RM_RD1;
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (pos_ff == PW'(1)) begin
               ram_wr_en = 1'b1;
               state_in  = ST_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = parent_m1[AW-1:0];
               state_in    = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            ram_wr_en = 1'b1;
            if (cmp_gt) begin
               ram_wr_data = ram_rd_data;
               pos_in      = parent;
               state_in    = ST_UP_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RM_RD1: begin
            mk_in       = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = cnt_m1[AW-1:0];
            state_in    = ST_RM_RD2;
         end
         ST_RM_RD2: begin
            val_in   = ram_rd_data;
            cnt_in   = cnt_m1;
            pos_in   = PW'(1);
            state_in = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (left_out) begin
               ram_wr_en = 1'b1;
               state_in  = ST_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = left_m1[AW-1:0];
               state_in    = ST_DN_LD;
            end
         end
         ST_DN_LD: begin
            ckey_in  = ram_rd_data;
            child_in = left[PW-1:0];
            if (right_in) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = left[AW-1:0];
               state_in    = ST_DN_SEL;
            end else begin
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_SEL: begin
            if (!cmp_gt) begin
               ckey_in  = ram_rd_data;
               child_in = child_ff + PW'(1);
            end
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            ram_wr_en = 1'b1;
            if (cmp_gt) begin
               ram_wr_data = ckey_ff;
               pos_in      = child_ff;
               state_in    = ST_DN_CHK;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      pos_ff    <= pos_in;
      child_ff  <= child_in;
      val_ff    <= val_in;
      ckey_ff   <= ckey_in;
      mk_ff     <= mk_in;
      status_ff <= status_in;
   end

   assign cnt_wide    = {{mhpq_pkg::COUNT_W{1'b0}}, cnt_ff};
   assign req_ready   = (state_ff == ST_IDLE);
   assign res_valid   = (state_ff == ST_RESP);
   assign res.max_key = mk_ff;
   assign res.status  = status_ff;
   assign res.count   = cnt_wide[mhpq_pkg::COUNT_W-1:0];

endmodule

FILE: hdl/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: sequencer, heap RAM and result register.
// Depends on mhpq_pkg, mhpq_ram and mhpq_ctrl.
`timescale 1ns / 1ps

// A binary max-heap of up to CAPACITY signed 32-bit keys. Each request either inserts
// req_key or removes the largest key, and gives exactly one response with the removed key,
// a status and the count afterward. The request side is busy while one operation runs:
// every level of a sift goes through the single read port of the heap RAM and one shared
// comparator. An insert sifts the new key up from the last slot until it reaches the root
// or meets a parent that is not smaller; a removal moves the last key to the root and sifts
// it down until it reaches a leaf or no child is larger. A refused request (full or empty)
// is answered without a sift. A finished response waits in an output register, so the next
// request is taken while it is still pending.
module max_heap_priority_queue #(
   parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_cmd,
   input  logic signed [mhpq_pkg::KEY_W-1:0]  req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [mhpq_pkg::KEY_W-1:0]  rsp_max_key,
   output logic [1:0]                         rsp_status,
   output logic [mhpq_pkg::COUNT_W-1:0]       rsp_count
);

   localparam int AW = $clog2(CAPACITY);

   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [mhpq_pkg::KEY_W-1:0]  ram_wr_data;
   logic                        ram_rd_en;
   logic [AW-1:0]               ram_rd_addr;
   logic [mhpq_pkg::KEY_W-1:0]  ram_rd_data;

   logic                        res_valid;
   logic                        res_ready;
   mhpq_pkg::result_type        res;

   logic                        rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::result_type        rsp_ff, rsp_in;

   mhpq_ram #(
      .WIDTH (mhpq_pkg::KEY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mhpq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_key     (req_key),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_max_key = rsp_ff.max_key;
   assign rsp_status  = rsp_ff.status;
   assign rsp_count   = rsp_ff.count;

endmodule
